FILE: design/spectrum_waterfall_colormap_core_defines.svh
// Assertion macros shared by the spectrum waterfall colour mapper.
`ifndef SPECTRUM_WATERFALL_COLORMAP_CORE_DEFINES_SVH
`define SPECTRUM_WATERFALL_COLORMAP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising edge of clk, suspended while rst is high.
`define SWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("swc assertion failed");
// Checked at every rising edge of clk, reset included.
`define SWC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("swc assertion failed");
`else
`define SWC_ASSERT(lbl, prop)
`define SWC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: design/swc_pkg.sv
// Types, constants and the colour ramp function of the waterfall colour mapper.
`timescale 1ns / 1ps
package swc_pkg;

  localparam int unsigned PWR_W     = 16;  // bin power, dBFS with 8 fraction bits
  localparam int unsigned DIFF_W    = 17;  // difference of two powers
  localparam int unsigned COL_W     = 11;  // pixel column
  localparam int unsigned IDX_W     = 10;  // bin index field
  localparam int unsigned NORM_FRAC = 10;  // fraction bits of the normalised power
  localparam int unsigned NORM_W    = 11;  // 0..1024
  localparam int unsigned COMP_W    = 8;   // one colour component
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BINS_FIELD_W  = 11;
  localparam int unsigned WIDTH_FIELD_W = 12;

  localparam logic [NORM_W-1:0] NORM_ONE = 11'd1024;
  localparam logic [COMP_W-1:0] COMP_FULL = 8'd255;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_FLOOR   = 2'd0,
    REG_POWER_CEILING = 2'd1,
    REG_BINS_IN_USE   = 2'd2,
    REG_ROW_WIDTH     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PICK,
    S_PICK_WAIT,
    S_READ,
    S_NORM,
    S_NORM_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swc_div_stat_t;

  typedef struct packed {
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] red;
  } pixel_t;

  // floor(255*f/256) for f in 0..256.
  function automatic logic [COMP_W-1:0] ramp_part(input logic [8:0] f);
    logic [16:0] prod;
    prod = {8'd0, f} * 17'd255;
    return prod[15:8];
  endfunction

  // Black-blue-cyan-yellow-white ramp in four equal segments.
  function automatic pixel_t ramp_colour(input logic [NORM_W-1:0] n);
    pixel_t     px;
    logic [1:0] seg;
    logic [8:0] f;
    seg = n[10] ? 2'd3 : n[9:8];
    f   = n[10] ? 9'd256 : {1'b0, n[7:0]};
    unique case (seg)
      2'd0: begin
        px.red = '0; px.green = '0; px.blue = ramp_part(f);
      end
      2'd1: begin
        px.red = '0; px.green = ramp_part(f); px.blue = COMP_FULL;
      end
      2'd2: begin
        px.red = ramp_part(f); px.green = COMP_FULL;
        px.blue = ramp_part(9'd256 - f);
      end
      default: begin
        px.red = COMP_FULL; px.green = COMP_FULL; px.blue = ramp_part(f);
      end
    endcase
    return px;
  endfunction

endpackage

FILE: design/swc_divider.sv
// Shared restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module swc_divider #(
  parameter int unsigned NUM_W  = 24,
  parameter int unsigned DIV_W  = 17,
  parameter int unsigned STEP_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [STEP_W-1:0]     steps,
  input  logic [DIV_W-1:0]      rem_init,
  input  logic [NUM_W-1:0]      dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic [NUM_W-1:0]      quotient,
  output swc_pkg::swc_div_stat_t stat
);
  import swc_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [NUM_W-1:0]  dvd;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // The remainder is always below the divisor, so one extra bit holds the trial.
  assign trial = {rem, dvd[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      // Completion is flagged for one cycle after the last quotient bit.
      stat.done <= !start && stat.busy && (cnt == STEP_W'(1));
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= steps;
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      dvd      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd      <= {dvd[NUM_W-2:0], 1'b0};
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

FILE: design/swc_store.sv
// Spectrum bin memory with one write port and a registered read port.
`timescale 1ns / 1ps
module swc_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [swc_pkg::PWR_W-1:0]   wdata,
  input  logic [AW-1:0]                      raddr,
  output logic signed [swc_pkg::PWR_W-1:0]   rdata
);
  import swc_pkg::*;

  logic signed [PWR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/spectrum_waterfall_colormap_core.sv
// Top level of the waterfall colour mapper: sequencer, registers and output stage.
`timescale 1ns / 1ps
`include "spectrum_waterfall_colormap_core_defines.svh"
// The block keeps a store of spectrum bins and turns pixel column requests into
// colours. Items arrive on the s_ stream; s_tuser selects a load (write one bin)
// or a render (produce one pixel). Each render yields one transaction on the m_
// stream carrying the column and its red, green and blue components; a load
// yields nothing. The cfg port sets floor, ceiling, bins in use and row width,
// and may only be written while the block is idle.
// A load does not leave the idle state, so the block is ready again at once.
// A render raises m_tvalid once its pixel is computed, and s_tready is low
// throughout: the sequencer multiplies, starts the shared divider, runs the
// bin pick (one quotient bit per cycle over 2 + 11 + ceil(log2(MAX_BINS+1))
// bits, then reports completion), does the registered memory read, starts
// the normalisation, waits for its ten quotient bits, and loads the output
// register. A single column skips the pick division; a power on or outside
// the range skips the normalisation.
// The result sits in an output register, so the next item is accepted while a
// finished pixel waits; if the receiver still stalls when the following render
// completes, the sequencer holds in its final state until the register frees.
// A synchronous reset restores the register defaults and empties the output
// register; the bin store keeps its contents and a bin must be loaded before
// it is rendered.
module spectrum_waterfall_colormap_core #(
  parameter int unsigned MAX_BINS    = 1024,
  parameter int unsigned MAX_COLUMNS = 2048
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // bin_index [9:0], bin_power [25:10], column [36:26], zero fill above
  input  logic [swc_pkg::IN_DATA_W-1:0]       s_tdata,
  // command: 0 load a bin, 1 render a column
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_column [10:0], red [18:11], green [26:19], blue [34:27], zero fill above
  output logic [swc_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import swc_pkg::*;

  localparam int unsigned IW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned BW    = $clog2(MAX_BINS + 1);
  localparam int unsigned RWW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned PW    = COL_W + BW;            // column * (bins - 1)
  localparam int unsigned NUMW  = PW + 2;                // 2 * product + span
  localparam int unsigned DVW   = (RWW + 1 > DIFF_W) ? RWW + 1 : DIFF_W;
  localparam int unsigned STEPW = $clog2(NUMW + 1);
  localparam int unsigned BINS_RST  = (MAX_BINS < 1024) ? MAX_BINS : 1024;
  localparam int unsigned WIDTH_RST = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;

  // Configuration registers.
  logic signed [PWR_W-1:0] power_floor;
  logic signed [PWR_W-1:0] power_ceiling;
  logic [BW-1:0]           bins_in_use;
  logic [RWW-1:0]          row_width;

  logic signed [PWR_W-1:0]   cfg_sval;
  logic [BINS_FIELD_W-1:0]   cfg_bins;
  logic [WIDTH_FIELD_W-1:0]  cfg_width;

  assign cfg_sval  = signed'(cfg_data);
  assign cfg_bins  = cfg_data[BINS_FIELD_W-1:0];
  assign cfg_width = cfg_data[WIDTH_FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      power_floor   <= -16'sd30720;
      power_ceiling <= 16'sd0;
      bins_in_use   <= BW'(BINS_RST);
      row_width     <= RWW'(WIDTH_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POWER_FLOOR: begin
          // An inverted or empty range is refused.
          if (power_ceiling > cfg_sval) power_floor <= cfg_sval;
        end
        REG_POWER_CEILING: begin
          if (cfg_sval > power_floor) power_ceiling <= cfg_sval;
        end
        REG_BINS_IN_USE: begin
          if (cfg_bins == '0) bins_in_use <= BW'(1);
          else if (32'(cfg_bins) > MAX_BINS) bins_in_use <= BW'(MAX_BINS);
          else bins_in_use <= BW'(cfg_bins);
        end
        REG_ROW_WIDTH: begin
          if (cfg_width == '0) row_width <= RWW'(1);
          else if (32'(cfg_width) > MAX_COLUMNS) row_width <= RWW'(MAX_COLUMNS);
          else row_width <= RWW'(cfg_width);
        end
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [IDX_W-1:0]        in_bin_index;
  logic signed [PWR_W-1:0] in_bin_power;
  logic [COL_W-1:0]        in_column;
  logic                    s_fire;
  logic                    load_ok;

  assign in_bin_index = s_tdata[IDX_W-1:0];
  assign in_bin_power = signed'(s_tdata[IDX_W +: PWR_W]);
  assign in_column    = s_tdata[IDX_W + PWR_W +: COL_W];
  assign s_fire       = s_tvalid && s_tready;
  // A load aimed past the end of the store is dropped.
  assign load_ok      = (32'(in_bin_index) < MAX_BINS);

  // Sequencer state and working registers.
  state_t state;
  state_t state_next;

  logic [COL_W-1:0]        column;
  logic [BW-1:0]           bins_m1;
  logic [RWW-1:0]          span;
  logic [PW-1:0]           prod;
  logic [IW-1:0]           pick;
  logic [NORM_W-1:0]       n_val;
  logic signed [PWR_W-1:0] power;
  logic signed [DIFF_W-1:0] power_diff;
  logic signed [DIFF_W-1:0] power_range;
  logic                    out_free;

  assign bins_m1     = bins_in_use - 1'b1;
  assign span        = row_width - 1'b1;
  assign power_diff  = DIFF_W'(power) - DIFF_W'(power_floor);
  assign power_range = DIFF_W'(power_ceiling) - DIFF_W'(power_floor);
  assign out_free    = !m_tvalid || m_tready;

  // Shared divider.
  logic                div_start;
  logic [STEPW-1:0]    div_steps;
  logic [DVW-1:0]      div_rem_init;
  logic [NUMW-1:0]     div_dividend;
  logic [DVW-1:0]      div_divisor;
  logic [NUMW-1:0]     div_quo;
  swc_div_stat_t       div_stat;

  swc_divider #(
    .NUM_W  (NUMW),
    .DIV_W  (DVW),
    .STEP_W (STEPW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Bin store.
  logic store_we;

  assign store_we = s_fire && (cmd_t'(s_tuser) == CMD_LOAD) && load_ok;

  swc_store #(
    .DEPTH (MAX_BINS),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (IW'(in_bin_index)),
    .wdata (in_bin_power),
    .raddr (pick),
    .rdata (power)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire && (cmd_t'(s_tuser) == CMD_RENDER)) state_next = S_MUL;
      end
      S_MUL:       state_next = S_PICK;
      S_PICK:      state_next = (row_width == RWW'(1)) ? S_READ : S_PICK_WAIT;
      S_PICK_WAIT: if (div_stat.done) state_next = S_READ;
      S_READ:      state_next = S_NORM;
      S_NORM: begin
        if (power > power_floor && power < power_ceiling) state_next = S_NORM_WAIT;
        else state_next = S_EMIT;
      end
      S_NORM_WAIT: if (div_stat.done) state_next = S_EMIT;
      S_EMIT:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_steps    = STEPW'(NUMW);
    div_rem_init = '0;
    div_dividend = ({2'b00, prod} << 1) + NUMW'(span);
    div_divisor  = DVW'({span, 1'b0});
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_PICK: div_start = (row_width != RWW'(1));
      S_NORM: begin
        // Power strictly inside the range: (power - floor) * 1024 / range.
        div_start    = (power > power_floor) && (power < power_ceiling);
        div_steps    = STEPW'(NORM_FRAC);
        div_rem_init = DVW'(unsigned'(power_diff));
        div_dividend = '0;
        div_divisor  = DVW'(unsigned'(power_range));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_fire) column <= in_column;
      end
      S_MUL: prod <= PW'(column) * PW'(bins_m1);
      S_PICK: begin
        if (row_width == RWW'(1)) pick <= '0;
      end
      S_PICK_WAIT: begin
        // A column past the row end saturates at the last bin in use.
        if (div_stat.done) begin
          if (div_quo > NUMW'(bins_m1)) pick <= IW'(bins_m1);
          else pick <= IW'(div_quo);
        end
      end
      S_NORM: begin
        if (power <= power_floor) n_val <= '0;
        else if (power >= power_ceiling) n_val <= NORM_ONE;
      end
      S_NORM_WAIT: begin
        if (div_stat.done) n_val <= div_quo[NORM_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register.
  pixel_t px;
  logic   emit;

  assign px   = ramp_colour(n_val);
  assign emit = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= OUT_DATA_W'({px.blue, px.green, px.red, column});
    end
  end

  // A render that is taken occupies the sequencer from the next cycle on.
  `SWC_ASSERT(a_render_starts, s_fire && s_tuser |=> state == S_MUL)
  // The divider only reports completion while the sequencer waits for it.
  `SWC_ASSERT(a_div_done_expected, div_stat.done |-> state == S_PICK_WAIT || state == S_NORM_WAIT)
  // The chosen bin never lies beyond the bins in use.
  `SWC_ASSERT(a_pick_in_range, state == S_READ |-> BW'(pick) <= bins_m1)
  // The normalised power never exceeds one.
  `SWC_ASSERT(a_norm_in_range, state == S_EMIT |-> n_val <= NORM_ONE)
  // The input side is never ready while the divider is working.
  `SWC_ASSERT_ALWAYS(a_busy_not_ready, div_stat.busy |-> !s_tready)

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the waterfall colour mapper: stimulus, prediction and checks.
`timescale 1ns / 1ps
module tb_top;
  import swc_pkg::*;

  // The block holds one finished pixel and stalls in its last state until the
  // receiver frees the output register.
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 100;
  localparam int STORE_DEPTH     = 1024;
  localparam int COLUMN_LIMIT    = 2048;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  bin;
    logic [15:0] power;
    logic [10:0] column;
  } stimulus_t;

  typedef struct {
    logic [10:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_exp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_DATA_W-1:0]       s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]      m_tdata;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  spectrum_waterfall_colormap_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the register file. It only changes while the block is idle,
  // so the generator and the predictor can both read it safely.
  logic signed [15:0] floor_r = -16'sd30720;
  logic signed [15:0] ceil_r  = 16'sd0;
  int unsigned        bins_r  = 1024;
  int unsigned        width_r = 1024;

  logic signed [15:0] spectrum_mem [STORE_DEPTH];
  bit                 bin_loaded [STORE_DEPTH];

  stimulus_t  item_q [$];
  pixel_exp_t expected_px [$];
  stimulus_t  next_item;

  logic in_taken = 1'b0;
  int   sender_gap_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_req_id = 0;
  int   hold_seen_id = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   mismatch_count = 0;

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // A floor or ceiling write that would close or invert the range is dropped.
  function automatic void apply_reg(input cfg_reg_t r, input logic [15:0] v);
    case (r)
      REG_POWER_FLOOR: begin
        if (ceil_r > $signed(v)) floor_r = v;
      end
      REG_POWER_CEILING: begin
        if ($signed(v) > floor_r) ceil_r = v;
      end
      REG_BINS_IN_USE: begin
        bins_r = clamp_count(v[10:0], STORE_DEPTH);
      end
      REG_ROW_WIDTH: begin
        width_r = clamp_count(v[11:0], COLUMN_LIMIT);
      end
      default: begin
      end
    endcase
  endfunction

  // Nearest bin for a column, saturated at the last bin in use.
  function automatic int unsigned bin_for_column(input int unsigned col);
    longint unsigned span, pick, top;
    top = bins_r - 1;
    if (width_r <= 1) return 0;
    span = width_r - 1;
    pick = (2 * col * top + span) / (2 * span);
    return (pick > top) ? top : pick;
  endfunction

  function automatic logic [7:0] shade(input int unsigned f);
    return 8'((255 * f) >> 8);
  endfunction

  // Normalise the chosen bin between floor and ceiling and walk the colour ramp.
  function automatic pixel_exp_t paint_column(input logic [10:0] col);
    pixel_exp_t  px;
    longint      p, lo, hi;
    int unsigned n;
    p  = spectrum_mem[bin_for_column(col)];
    lo = floor_r;
    hi = ceil_r;
    if (p <= lo) n = 0;
    else if (p >= hi) n = 1024;
    else n = ((p - lo) * 1024) / (hi - lo);
    px.column = col;
    if (n < 256) begin
      px.red = 8'd0; px.green = 8'd0; px.blue = shade(n);
    end else if (n < 512) begin
      px.red = 8'd0; px.green = shade(n - 256); px.blue = 8'd255;
    end else if (n < 768) begin
      px.red = shade(n - 512); px.green = 8'd255; px.blue = shade(256 - (n - 512));
    end else begin
      px.red = 8'd255; px.green = 8'd255; px.blue = shade(n - 768);
    end
    return px;
  endfunction

  // Powers cluster around the floor and ceiling and inside the range, with
  // a share drawn from the whole 16-bit span.
  function automatic logic [15:0] draw_power();
    int lo, hi, v;
    lo = floor_r;
    hi = ceil_r;
    case ($urandom_range(0, 3))
      0: v = $signed(16'($urandom));
      1: v = ($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 6)) - 3;
      default: v = lo + int'($urandom_range(0, hi - lo));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin sender_gap_pct = 55; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_gap_pct = 0;  recv_stall_pct = 55; end
      IDLE_BOTH:     begin sender_gap_pct = 30; recv_stall_pct = 30; end
      default:       begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  task automatic queue_load(input int unsigned idx, input logic [15:0] pwr);
    stimulus_t it;
    it.cmd    = CMD_LOAD;
    it.bin    = idx[9:0];
    it.power  = pwr;
    it.column = 11'($urandom);
    bin_loaded[idx] = 1'b1;
    item_q.push_back(it);
  endtask

  // A render never reads a bin that has not been loaded since reset: when the
  // chosen bin is still empty, a load of it goes out first.
  task automatic queue_render(input int unsigned col);
    stimulus_t   it;
    int unsigned pick;
    pick = bin_for_column(col);
    if (!bin_loaded[pick]) queue_load(pick, draw_power());
    it.cmd    = CMD_RENDER;
    it.bin    = 10'($urandom);
    it.power  = 16'($urandom);
    it.column = col[10:0];
    item_q.push_back(it);
  endtask

  task automatic queue_random(input int count);
    int unsigned col;
    repeat (count) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 1)) queue_load($urandom_range(0, STORE_DEPTH - 1), draw_power());
        else queue_load($urandom_range(0, bins_r - 1), draw_power());
      end else begin
        if ($urandom_range(0, 99) < 85) col = $urandom_range(0, width_r - 1);
        else col = $urandom_range(0, COLUMN_LIMIT - 1);
        queue_render(col);
      end
    end
  endtask

  // The write enable drops for a cycle between writes, so no signal is given
  // two nonblocking assignments in one time step.
  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(r, v);
  endtask

  // Waits until every item has been taken and every pixel has come back, then
  // lets the block finish whatever it may still be doing.
  task automatic wait_idle();
    while (item_q.size() != 0 || s_tvalid || expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input idle_mode_t mode, input int count);
    set_idling(mode);
    queue_random(count);
    wait_idle();
  endtask

  // Driver: presents the next pending item at the falling edge once the
  // previous transaction has completed, with random gaps as the phase asks.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        next_item = item_q.pop_front();
        s_tvalid  <= 1'b1;
        s_tuser   <= next_item.cmd;
        s_tdata   <= {3'b000, next_item.column, next_item.power, next_item.bin};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so that the
  // output register fills and the block has to refuse input.
  always @(negedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: an accepted input transaction updates the predicted store or
  // queues the expected pixel; an accepted output transaction is checked
  // field by field against the oldest expectation.
  pixel_exp_t want_px;
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_px.size() == 0) begin
        report_error($sformatf("pixel for column %0d with nothing expected", m_tdata[10:0]));
      end else begin
        want_px = expected_px.pop_front();
        if (m_tdata[10:0] !== want_px.column)
          report_error($sformatf("column %0d, expected %0d", m_tdata[10:0], want_px.column));
        if (m_tdata[18:11] !== want_px.red)
          report_error($sformatf("column %0d red %0d, expected %0d",
                                 want_px.column, m_tdata[18:11], want_px.red));
        if (m_tdata[26:19] !== want_px.green)
          report_error($sformatf("column %0d green %0d, expected %0d",
                                 want_px.column, m_tdata[26:19], want_px.green));
        if (m_tdata[34:27] !== want_px.blue)
          report_error($sformatf("column %0d blue %0d, expected %0d",
                                 want_px.column, m_tdata[34:27], want_px.blue));
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      if (cmd_t'(s_tuser) == CMD_LOAD) spectrum_mem[s_tdata[9:0]] = s_tdata[25:10];
      else expected_px.push_back(paint_column(s_tdata[36:26]));
    end
  end

  // Watchdog: too long without any transaction on either stream ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: floor 0 and ceiling 1024 make the normalised value equal
    // the power, and sixteen bins across sixteen columns map column to bin.
    write_reg(REG_POWER_CEILING, 16'd1024);
    write_reg(REG_POWER_FLOOR, 16'd0);
    // Writes that would close or invert the range must be ignored.
    write_reg(REG_POWER_FLOOR, 16'd1024);
    write_reg(REG_POWER_FLOOR, 16'd2000);
    write_reg(REG_POWER_CEILING, 16'd0);
    write_reg(REG_POWER_CEILING, -16'sd100);
    write_reg(REG_BINS_IN_USE, 16'd16);
    write_reg(REG_ROW_WIDTH, 16'd16);
    set_idling(IDLE_NONE);
    // Below the floor, on it, each segment boundary, on the ceiling and above.
    queue_load(0, 16'h8000);
    queue_load(1, 16'd0);
    queue_load(2, 16'd255);
    queue_load(3, 16'd256);
    queue_load(4, 16'd511);
    queue_load(5, 16'd512);
    queue_load(6, 16'd767);
    queue_load(7, 16'd768);
    queue_load(8, 16'd1023);
    queue_load(9, 16'd1024);
    queue_load(10, 16'h7FFF);
    queue_load(15, 16'd128);
    queue_load(STORE_DEPTH - 1, 16'h5A5A);
    for (int c = 0; c <= 10; c++) queue_render(c);
    // A column far beyond the row saturates at the last bin in use.
    queue_render(COLUMN_LIMIT - 1);
    wait_idle();

    // Reset settings.
    write_reg(REG_POWER_FLOOR, -16'sd30720);
    write_reg(REG_POWER_CEILING, 16'd0);
    write_reg(REG_BINS_IN_USE, 16'd1024);
    write_reg(REG_ROW_WIDTH, 16'd1024);
    run_phase(IDLE_NONE, 80);

    // Full power span; bin count and width written beyond range saturate.
    write_reg(REG_POWER_CEILING, 16'h7FFF);
    write_reg(REG_POWER_FLOOR, 16'h8000);
    write_reg(REG_BINS_IN_USE, 16'hFFFF);
    write_reg(REG_ROW_WIDTH, 16'd4095);
    run_phase(IDLE_SENDER, 80);

    // Narrowest range, so every pixel is black or white; few columns.
    write_reg(REG_POWER_FLOOR, 16'd100);
    write_reg(REG_POWER_CEILING, 16'd101);
    write_reg(REG_BINS_IN_USE, 16'd300);
    write_reg(REG_ROW_WIDTH, 16'd7);
    run_phase(IDLE_RECEIVER, 80);

    // Zero counts saturate to one bin and one column.
    write_reg(REG_POWER_FLOOR, -16'sd5000);
    write_reg(REG_POWER_CEILING, 16'd5000);
    write_reg(REG_BINS_IN_USE, 16'd0);
    write_reg(REG_ROW_WIDTH, 16'd0);
    run_phase(IDLE_BOTH, 70);

    // Back-pressure: the receiver holds off while the sender keeps offering.
    write_reg(REG_POWER_FLOOR, -16'sd1000);
    write_reg(REG_POWER_CEILING, 16'd3000);
    write_reg(REG_BINS_IN_USE, 16'd2);
    write_reg(REG_ROW_WIDTH, 16'd2048);
    hold_req_id++;
    run_phase(IDLE_NONE, 90);

    // Range of one step at the bottom of the span; two columns.
    write_reg(REG_POWER_FLOOR, 16'h8000);
    write_reg(REG_POWER_CEILING, -16'sd32767);
    write_reg(REG_BINS_IN_USE, 16'd1024);
    write_reg(REG_ROW_WIDTH, 16'd2);
    run_phase(IDLE_SENDER, 70);

    // Range of one step at the top of the span.
    write_reg(REG_POWER_CEILING, 16'h7FFF);
    write_reg(REG_POWER_FLOOR, 16'd32766);
    write_reg(REG_BINS_IN_USE, 16'd1000);
    write_reg(REG_ROW_WIDTH, 16'd2000);
    run_phase(IDLE_RECEIVER, 70);

    // Upper data bits above the bin count field are dropped: 513 bins.
    write_reg(REG_POWER_FLOOR, -16'sd20000);
    write_reg(REG_POWER_CEILING, 16'd20000);
    write_reg(REG_BINS_IN_USE, 16'h0A01);
    write_reg(REG_ROW_WIDTH, 16'd1500);
    run_phase(IDLE_BOTH, 70);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
